// File: rtl/core/sphit_pkg.sv
package sphit_pkg;

    // item opcodes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_POINT  = 3'd1;
    localparam logic [2:0] OP_CIRCLE = 3'd2;
    localparam logic [2:0] OP_FIRST  = 3'd3;
    localparam logic [2:0] OP_NEXT   = 3'd4;
    localparam logic [2:0] OP_RECT   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_QUERY_X   = 2'd0;
    localparam logic [1:0] REG_QUERY_Y   = 2'd1;
    localparam logic [1:0] REG_PRECISION = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_THR, S_PT1, S_PT2, S_PT3,
        S_L1, S_L2, S_D1, S_D2, S_BR,
        S_W1, S_W2, S_E1, S_E2, S_NEAR,
        S_C1, S_C2, S_CS, S_X1, S_X2, S_X3, S_X4,
        S_R1, S_R2, S_R3, S_R4, S_RC, S_NEXT, S_FIN
    } t_state;

    // multiplier operand sources
    typedef enum logic [3:0] {
        M_NONE, M_DX, M_DY, M_WX, M_WY, M_EX, M_EY, M_PREC, M_RADP,
        M_CROSS_LO, M_CROSS_HI, M_THR_LO, M_THR_HI, M_LEN_LO, M_LEN_HI
    } t_msrc;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, WIDE_LOAD, WIDE_ADD
    } t_accop;

    typedef enum logic [2:0] {
        SV_NONE, SV_THR, SV_LEN, SV_CROSS, SV_BIG
    } t_save;

    typedef enum logic [2:0] {
        F_NONE, F_CLEAR, F_ASSIGN_NEAR, F_SET_NEAR, F_SET_WIDE
    } t_flagop;

    typedef enum logic [1:0] {
        EP_NONE, EP_POINT, EP_VERTEX, EP_EDGE
    } t_epsel;

    typedef struct packed {
        t_msrc      msrc_a;
        t_msrc      msrc_b;
        t_accop     acc_op;
        t_save      save;
        t_flagop    flag_op;
        t_epsel     ep_sel;
        logic [1:0] edge_idx;
        logic       prev_load;
        logic       take;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       single;
        logic       dot_le0;
        logic       dot_ge_len;
    } t_status;

endpackage

// File: rtl/core/sphit_item_if.sv
interface sphit_item_if #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    opcode;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] corner_x;
    logic signed [COORD_WIDTH-1:0] corner_y;
    logic [COORD_WIDTH-2:0]        radius;
    logic                          single;

    modport source (
        output valid, opcode, coord_x, coord_y, corner_x, corner_y, radius, single,
        input  ready
    );
    modport sink (
        input  valid, opcode, coord_x, coord_y, corner_x, corner_y, radius, single,
        output ready
    );
endinterface

// File: rtl/core/sphit_result_if.sv
interface sphit_result_if ();
    logic valid;
    logic ready;
    logic is_at;

    modport source (
        output valid, is_at,
        input  ready
    );
    modport sink (
        input  valid, is_at,
        output ready
    );
endinterface

// File: rtl/core/sphit_dp.sv
module sphit_dp import sphit_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic [2:0]                    i_opcode,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_y,
    input  logic [COORD_WIDTH-2:0]        i_radius,
    input  logic                          i_single,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    output logic                          o_flag
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int XW = 2 * PW;

    // configuration and state
    logic signed [W-1:0]  r_qx, r_qy, r_prev_x, r_prev_y;
    logic [W-2:0]         r_prec;
    logic                 r_flag;

    // latched transaction
    logic [2:0]           r_op;
    logic                 r_single;
    logic signed [W-1:0]  r_cx, r_cy, r_kx, r_ky;
    logic [W-2:0]         r_rad;

    // working registers
    logic signed [DW-1:0] r_dx, r_dy, r_wx, r_wy, r_ex, r_ey;
    logic signed [AW-1:0] r_acc;
    logic [XW-1:0]        r_wide, r_big;
    logic [PW-1:0]        r_thr, r_len, r_cross;

    logic signed [W-1:0]  e_lx, e_rx, e_ty, e_by;
    logic signed [W-1:0]  ax, ay, bx, by;
    logic [DW+1:0]        op_a, op_b;
    logic [PW-1:0]        prod;
    logic signed [AW-1:0] sprod;
    logic [XW-1:0]        wprod;
    logic [AW-1:0]        acc_mag;
    logic                 near, wide_hit;

    function automatic logic [DW:0] sabs(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(~v + 1'b1) : DW'(v);
        return {v[DW-1], m};
    endfunction

    // operand word: {high half, negative, magnitude}
    function automatic logic [DW+1:0] pick(input t_msrc s);
        logic [DW+1:0] w;
        case (s)
            M_DX:       w = {1'b0, sabs(r_dx)};
            M_DY:       w = {1'b0, sabs(r_dy)};
            M_WX:       w = {1'b0, sabs(r_wx)};
            M_WY:       w = {1'b0, sabs(r_wy)};
            M_EX:       w = {1'b0, sabs(r_ex)};
            M_EY:       w = {1'b0, sabs(r_ey)};
            M_PREC:     w = {2'b00, DW'(r_prec)};
            M_RADP:     w = {2'b00, DW'(r_rad) + DW'(r_prec)};
            M_CROSS_LO: w = {2'b00, r_cross[DW-1:0]};
            M_CROSS_HI: w = {2'b10, r_cross[PW-1:DW]};
            M_THR_LO:   w = {2'b00, r_thr[DW-1:0]};
            M_THR_HI:   w = {2'b10, r_thr[PW-1:DW]};
            M_LEN_LO:   w = {2'b00, r_len[DW-1:0]};
            M_LEN_HI:   w = {2'b10, r_len[PW-1:DW]};
            default:    w = '0;
        endcase
        return w;
    endfunction

    // rectangle bounds
    always_comb begin
        e_lx = (r_cx < r_kx) ? r_cx : r_kx;
        e_rx = (r_cx < r_kx) ? r_kx : r_cx;
        e_ty = (r_cy < r_ky) ? r_cy : r_ky;
        e_by = (r_cy < r_ky) ? r_ky : r_cy;
    end

    // segment end points
    always_comb begin
        ax = r_cx; ay = r_cy; bx = r_cx; by = r_cy;
        case (i_cmd.ep_sel)
            EP_VERTEX: begin
                ax = r_prev_x; ay = r_prev_y;
            end
            EP_EDGE: begin
                case (i_cmd.edge_idx)
                    2'd0: begin
                        ax = e_lx; ay = e_ty; bx = e_rx; by = e_ty;
                    end
                    2'd1: begin
                        ax = e_rx; ay = e_ty; bx = e_rx; by = e_by;
                    end
                    2'd2: begin
                        ax = e_rx; ay = e_by; bx = e_lx; by = e_by;
                    end
                    default: begin
                        ax = e_lx; ay = e_by; bx = e_lx; by = e_ty;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // shared multiplier
    always_comb begin
        op_a  = pick(i_cmd.msrc_a);
        op_b  = pick(i_cmd.msrc_b);
        prod  = PW'(op_a[DW-1:0]) * PW'(op_b[DW-1:0]);
        sprod = (op_a[DW] ^ op_b[DW]) ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
        if (op_a[DW+1] && op_b[DW+1]) begin
            wprod = XW'(prod) << (2 * DW);
        end else if (op_a[DW+1] || op_b[DW+1]) begin
            wprod = XW'(prod) << DW;
        end else begin
            wprod = XW'(prod);
        end
        acc_mag  = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        near     = !r_acc[AW-1] && (r_acc[PW-1:0] < r_thr);
        wide_hit = r_big < r_wide;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx   <= '0;
            r_qy   <= '0;
            r_prec <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_QUERY_X:   r_qx   <= i_cfg_data;
                REG_QUERY_Y:   r_qy   <= i_cfg_data;
                REG_PRECISION: r_prec <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // hit flag and previous vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            case (i_cmd.flag_op)
                F_CLEAR:       r_flag <= 1'b0;
                F_ASSIGN_NEAR: r_flag <= near;
                F_SET_NEAR:    r_flag <= r_flag | near;
                F_SET_WIDE:    r_flag <= r_flag | wide_hit;
                default: ;
            endcase
            if (i_cmd.prev_load) begin
                r_prev_x <= r_cx;
                r_prev_y <= r_cy;
            end
        end
    end

    // transaction latch, differences, accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_opcode;
            r_single <= i_single;
            r_cx     <= i_coord_x;
            r_cy     <= i_coord_y;
            r_kx     <= i_corner_x;
            r_ky     <= i_corner_y;
            r_rad    <= i_radius;
        end
        if (i_cmd.ep_sel != EP_NONE) begin
            r_dx <= DW'(bx) - DW'(ax);
            r_dy <= DW'(by) - DW'(ay);
            r_wx <= DW'(r_qx) - DW'(ax);
            r_wy <= DW'(r_qy) - DW'(ay);
            r_ex <= DW'(r_qx) - DW'(bx);
            r_ey <= DW'(r_qy) - DW'(by);
        end
        case (i_cmd.acc_op)
            ACC_LOAD:  r_acc  <= sprod;
            ACC_ADD:   r_acc  <= r_acc + sprod;
            ACC_SUB:   r_acc  <= r_acc - sprod;
            WIDE_LOAD: r_wide <= wprod;
            WIDE_ADD:  r_wide <= r_wide + wprod;
            default: ;
        endcase
        case (i_cmd.save)
            SV_THR:   r_thr   <= acc_mag[PW-1:0];
            SV_LEN:   r_len   <= acc_mag[PW-1:0];
            SV_CROSS: r_cross <= acc_mag[PW-1:0];
            SV_BIG:   r_big   <= r_wide;
            default: ;
        endcase
    end

    assign o_status.op         = r_op;
    assign o_status.single     = r_single;
    assign o_status.dot_le0    = r_acc[AW-1] || (r_acc == '0);
    assign o_status.dot_ge_len = !r_acc[AW-1] && (r_acc[PW-1:0] >= r_len);
    assign o_flag              = r_flag;

endmodule

// File: rtl/core/sphit_ctrl.sv
module sphit_ctrl import sphit_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_out_free,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_result_load,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_edge, n_edge;
    logic       is_seg_op, more_edges;

    assign is_seg_op  = (i_status.op == OP_NEXT) || (i_status.op == OP_RECT);
    assign more_edges = (i_status.op == OP_RECT) && (r_edge != 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_edge  <= '0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        unique case (r_state)
            S_IDLE:  if (i_accept) n_state = S_START;
            S_START: begin
                n_edge = '0;
                unique case (i_status.op) inside
                    OP_POINT, OP_CIRCLE, OP_NEXT, OP_RECT: n_state = S_THR;
                    OP_FIRST: n_state = i_status.single ? S_THR : S_FIN;
                    default:  n_state = S_FIN;
                endcase
            end
            S_THR:   n_state = is_seg_op ? S_L1 : S_PT1;
            S_PT1:   n_state = S_PT2;
            S_PT2:   n_state = S_PT3;
            S_PT3:   n_state = S_FIN;
            S_L1:    n_state = S_L2;
            S_L2:    n_state = S_D1;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_BR;
            S_BR: begin
                if (i_status.dot_le0) begin
                    n_state = S_W1;
                end else if (i_status.dot_ge_len) begin
                    n_state = S_E1;
                end else begin
                    n_state = S_C1;
                end
            end
            S_W1:    n_state = S_W2;
            S_W2:    n_state = S_NEAR;
            S_E1:    n_state = S_E2;
            S_E2:    n_state = S_NEAR;
            S_NEAR:  n_state = S_NEXT;
            S_C1:    n_state = S_C2;
            S_C2:    n_state = S_CS;
            S_CS:    n_state = S_X1;
            S_X1:    n_state = S_X2;
            S_X2:    n_state = S_X3;
            S_X3:    n_state = S_X4;
            S_X4:    n_state = S_R1;
            S_R1:    n_state = S_R2;
            S_R2:    n_state = S_R3;
            S_R3:    n_state = S_R4;
            S_R4:    n_state = S_RC;
            S_RC:    n_state = S_NEXT;
            S_NEXT: begin
                if (more_edges) begin
                    n_state = S_L1;
                    n_edge  = r_edge + 2'd1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        o_result_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_accept;
            end
            S_START: begin
                o_cmd.ep_sel    = (i_status.op == OP_NEXT) ? EP_VERTEX :
                                  (i_status.op == OP_RECT) ? EP_EDGE : EP_POINT;
                o_cmd.msrc_a    = (i_status.op == OP_CIRCLE) ? M_RADP : M_PREC;
                o_cmd.msrc_b    = (i_status.op == OP_CIRCLE) ? M_RADP : M_PREC;
                o_cmd.acc_op    = ACC_LOAD;
                o_cmd.prev_load = (i_status.op == OP_FIRST);
                o_cmd.flag_op   = (i_status.op == OP_CLEAR) ? F_CLEAR : F_NONE;
            end
            S_THR: o_cmd.save = SV_THR;
            S_PT1: begin
                o_cmd.msrc_a = M_EX; o_cmd.msrc_b = M_EX; o_cmd.acc_op = ACC_LOAD;
            end
            S_PT2: begin
                o_cmd.msrc_a = M_EY; o_cmd.msrc_b = M_EY; o_cmd.acc_op = ACC_ADD;
            end
            S_PT3: o_cmd.flag_op = F_ASSIGN_NEAR;
            S_L1: begin
                o_cmd.msrc_a = M_DX; o_cmd.msrc_b = M_DX; o_cmd.acc_op = ACC_LOAD;
            end
            S_L2: begin
                o_cmd.msrc_a = M_DY; o_cmd.msrc_b = M_DY; o_cmd.acc_op = ACC_ADD;
            end
            S_D1: begin
                o_cmd.save   = SV_LEN;
                o_cmd.msrc_a = M_WX; o_cmd.msrc_b = M_DX; o_cmd.acc_op = ACC_LOAD;
            end
            S_D2: begin
                o_cmd.msrc_a = M_WY; o_cmd.msrc_b = M_DY; o_cmd.acc_op = ACC_ADD;
            end
            S_W1: begin
                o_cmd.msrc_a = M_WX; o_cmd.msrc_b = M_WX; o_cmd.acc_op = ACC_LOAD;
            end
            S_W2: begin
                o_cmd.msrc_a = M_WY; o_cmd.msrc_b = M_WY; o_cmd.acc_op = ACC_ADD;
            end
            S_E1: begin
                o_cmd.msrc_a = M_EX; o_cmd.msrc_b = M_EX; o_cmd.acc_op = ACC_LOAD;
            end
            S_E2: begin
                o_cmd.msrc_a = M_EY; o_cmd.msrc_b = M_EY; o_cmd.acc_op = ACC_ADD;
            end
            S_NEAR: o_cmd.flag_op = F_SET_NEAR;
            S_C1: begin
                o_cmd.msrc_a = M_WX; o_cmd.msrc_b = M_DY; o_cmd.acc_op = ACC_LOAD;
            end
            S_C2: begin
                o_cmd.msrc_a = M_WY; o_cmd.msrc_b = M_DX; o_cmd.acc_op = ACC_SUB;
            end
            S_CS: o_cmd.save = SV_CROSS;
            S_X1: begin
                o_cmd.msrc_a = M_CROSS_LO; o_cmd.msrc_b = M_CROSS_LO;
                o_cmd.acc_op = WIDE_LOAD;
            end
            S_X2: begin
                o_cmd.msrc_a = M_CROSS_LO; o_cmd.msrc_b = M_CROSS_HI;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_X3: begin
                o_cmd.msrc_a = M_CROSS_HI; o_cmd.msrc_b = M_CROSS_LO;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_X4: begin
                o_cmd.msrc_a = M_CROSS_HI; o_cmd.msrc_b = M_CROSS_HI;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_R1: begin
                o_cmd.save   = SV_BIG;
                o_cmd.msrc_a = M_THR_LO; o_cmd.msrc_b = M_LEN_LO;
                o_cmd.acc_op = WIDE_LOAD;
            end
            S_R2: begin
                o_cmd.msrc_a = M_THR_LO; o_cmd.msrc_b = M_LEN_HI;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_R3: begin
                o_cmd.msrc_a = M_THR_HI; o_cmd.msrc_b = M_LEN_LO;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_R4: begin
                o_cmd.msrc_a = M_THR_HI; o_cmd.msrc_b = M_LEN_HI;
                o_cmd.acc_op = WIDE_ADD;
            end
            S_RC: o_cmd.flag_op = F_SET_WIDE;
            S_NEXT: begin
                if (more_edges) begin
                    o_cmd.ep_sel   = EP_EDGE;
                    o_cmd.edge_idx = r_edge + 2'd1;
                end
                o_cmd.prev_load = (i_status.op == OP_NEXT);
            end
            S_FIN: o_result_load = i_out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/shape_proximity_hit_test.sv
// clear and unused opcodes go straight to the result, point/circle/single vertex compute
// one squared distance, one segment or each of the four rectangle edges uses a projection
// test (segment path depends on whether the projection is clamped to an end point)
// throughput: one transaction at a time, all products go through one shared multiplier
// input ready rises in the cycle after the result is loaded into the output register
// reset: synchronous active low, clears config, hit flag, previous vertex and control
module shape_proximity_hit_test import sphit_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sphit_item_if.sink             i_item,
    sphit_result_if.source         o_result,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    item_acc, out_free, res_load, in_ready, dp_flag;
    logic    r_res_valid, r_res_is_at;

    assign item_acc = i_item.valid && in_ready;
    assign out_free = !r_res_valid || o_result.ready;

    sphit_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (item_acc),
        .i_out_free    (out_free),
        .i_status      (status),
        .o_in_ready    (in_ready),
        .o_result_load (res_load),
        .o_cmd         (cmd)
    );

    sphit_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_item.opcode),
        .i_coord_x  (i_item.coord_x),
        .i_coord_y  (i_item.coord_y),
        .i_corner_x (i_item.corner_x),
        .i_corner_y (i_item.corner_y),
        .i_radius   (i_item.radius),
        .i_single   (i_item.single),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_flag     (dp_flag)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) r_res_is_at <= dp_flag;
    end

    assign i_item.ready   = in_ready;
    assign o_result.valid = r_res_valid;
    assign o_result.is_at = r_res_is_at;

    // busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_acc |=> !in_ready)
        else $error("input ready while a transaction is in work");

    // result register is never overwritten while still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_res_valid || o_result.ready))
        else $error("result loaded into a full output register");

    // clear drops the flag before the result is produced
    a_clear_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && i_item.opcode == OP_CLEAR) |-> ##2 !dp_flag)
        else $error("flag not cleared by clear transaction");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import sphit_pkg::*;

    localparam int CW = 24;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]           opcode;
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic signed [CW-1:0] corner_x;
        logic signed [CW-1:0] corner_y;
        logic [CW-2:0]        radius;
        logic                 single;
    } shape_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = REG_QUERY_X;
    logic [CW-1:0] i_cfg_data = '0;

    sphit_item_if #(.COORD_WIDTH(CW)) item_ch ();
    sphit_result_if result_ch ();

    shape_proximity_hit_test #(.COORD_WIDTH(CW)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state and configuration
    logic signed [CW-1:0] qry_x = '0, qry_y = '0;
    logic [CW-2:0]        tol = '0;
    logic                 hit = 1'b0;
    logic signed [CW-1:0] last_x = '0, last_y = '0;

    shape_t pending_shapes[$];
    bit     expected_flags[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     stim_done = 1'b0;
    bit     hold_sender = 1'b0;
    int     rx_hold = 0;

    function automatic logic [63:0] sq_len(longint dx, longint dy);
        logic [63:0] ax, ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    function automatic bit near_point(longint x, longint y);
        logic [63:0] p;
        p = tol;
        return sq_len(longint'(qry_x) - x, longint'(qry_y) - y) < p * p;
    endfunction

    // exact clamped-projection distance test, compared in 128 bits
    function automatic bit near_segment(longint ax, longint ay, longint bx, longint by);
        longint dx, dy, wx, wy, dot, crs;
        logic [63:0] p2, len2, ac;
        logic [127:0] lhs, rhs;
        p2 = 64'(tol) * 64'(tol);
        dx = bx - ax; dy = by - ay;
        wx = longint'(qry_x) - ax; wy = longint'(qry_y) - ay;
        dot = wx * dx + wy * dy;
        len2 = sq_len(dx, dy);
        if (dot <= 0) return sq_len(wx, wy) < p2;
        if (64'(dot) >= len2) return sq_len(longint'(qry_x) - bx, longint'(qry_y) - by) < p2;
        crs = wx * dy - wy * dx;
        ac = crs < 0 ? -crs : crs;
        lhs = 128'(ac) * 128'(ac);
        rhs = 128'(p2) * 128'(len2);
        return lhs < rhs;
    endfunction

    function automatic bit predict_hit(shape_t s);
        longint l, r, t, b;
        logic [63:0] rp;
        case (s.opcode)
            OP_CLEAR: hit = 1'b0;
            OP_POINT: hit = near_point(s.coord_x, s.coord_y);
            OP_CIRCLE: begin
                rp = 64'(s.radius) + 64'(tol);
                hit = sq_len(longint'(qry_x) - s.coord_x, longint'(qry_y) - s.coord_y)
                      < rp * rp;
            end
            OP_FIRST: begin
                last_x = s.coord_x; last_y = s.coord_y;
                if (s.single) hit = near_point(s.coord_x, s.coord_y);
            end
            OP_NEXT: begin
                if (near_segment(last_x, last_y, s.coord_x, s.coord_y)) hit = 1'b1;
                last_x = s.coord_x; last_y = s.coord_y;
            end
            OP_RECT: begin
                l = s.coord_x < s.corner_x ? s.coord_x : s.corner_x;
                r = s.coord_x < s.corner_x ? s.corner_x : s.coord_x;
                t = s.coord_y < s.corner_y ? s.coord_y : s.corner_y;
                b = s.coord_y < s.corner_y ? s.corner_y : s.coord_y;
                if (near_segment(l, t, r, t) || near_segment(r, t, r, b) ||
                    near_segment(r, b, l, b) || near_segment(l, b, l, t))
                    hit = 1'b1;
            end
            default: ;
        endcase
        return hit;
    endfunction

    // driver: bursts with random gaps
    int gap = 0;
    int burst = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                expected_flags.push_back(predict_hit(pending_shapes.pop_front()));
            end
            if (item_ch.valid && !item_ch.ready) begin
                // hold current transaction
            end else if (gap > 0 || hold_sender || pending_shapes.size() == 0) begin
                item_ch.valid <= 1'b0;
                if (gap > 0) gap <= gap - 1;
            end else begin
                shape_t s;
                s = pending_shapes[0];
                item_ch.valid    <= 1'b1;
                item_ch.opcode   <= s.opcode;
                item_ch.coord_x  <= s.coord_x;
                item_ch.coord_y  <= s.coord_y;
                item_ch.corner_x <= s.corner_x;
                item_ch.corner_y <= s.corner_y;
                item_ch.radius   <= s.radius;
                item_ch.single   <= s.single;
                if (burst == 0) begin
                    burst <= $urandom_range(1, 20);
                    gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst <= burst - 1;
                end
            end
        end
    end

    // monitor: receiver stalls on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_flags.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result is_at=%0b", result_ch.is_at);
                end else begin
                    bit e;
                    e = expected_flags.pop_front();
                    if (e !== result_ch.is_at) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("is_at mismatch: expected %0b actual %0b", e, result_ch.is_at);
                    end
                end
            end
            if (rx_hold > 0) begin
                result_ch.ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                result_ch.ready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic logic signed [CW-1:0] rnd_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'(int'(qry_x) + $urandom_range(0, 4000) - 2000);
            default: return CW'(int'(qry_y) + $urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic shape_t rnd_shape(logic [2:0] op);
        shape_t s;
        int far;
        far = ($urandom_range(0, 4) == 0) ? 0 : 1;
        s.opcode = op;
        s.coord_x = far == 0 ? rnd_coord(0) : rnd_coord(1);
        s.coord_y = far == 0 ? rnd_coord(0) : rnd_coord(2);
        s.corner_x = far == 0 ? rnd_coord(0) : rnd_coord(1);
        s.corner_y = far == 0 ? rnd_coord(0) : rnd_coord(2);
        s.radius = ($urandom_range(0, 3) == 0) ? (CW-1)'($urandom) : (CW-1)'($urandom_range(0, 1500));
        s.single = $urandom_range(0, 1);
        return s;
    endfunction

    // wait until every queued transaction is sent and answered, then hold the sender
    task automatic drain();
        while (pending_shapes.size() != 0 || item_ch.valid || expected_flags.size() != 0)
            @(posedge i_clk);
        hold_sender = 1'b1;
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_QUERY_X: qry_x = val;
            REG_QUERY_Y: qry_y = val;
            default:     tol = val[CW-2:0];
        endcase
    endtask

    task automatic add(logic [2:0] op, int x, int y, int cx, int cy, int r, bit sg);
        shape_t s;
        s.opcode = op; s.coord_x = CW'(x); s.coord_y = CW'(y);
        s.corner_x = CW'(cx); s.corner_y = CW'(cy); s.radius = (CW-1)'(r); s.single = sg;
        pending_shapes.push_back(s);
    endtask

    localparam int MAXC = 8388607;
    localparam int MINC = -8388608;

    initial begin
        item_ch.valid = 1'b0; item_ch.opcode = OP_CLEAR;
        item_ch.coord_x = '0; item_ch.coord_y = '0; item_ch.corner_x = '0;
        item_ch.corner_y = '0; item_ch.radius = '0; item_ch.single = 1'b0;
        result_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, degenerate shapes
        write_reg(REG_PRECISION, 24'd512);
        add(OP_NEXT, 100, 100, 0, 0, 0, 0);            // next vertex straight after reset
        add(OP_POINT, 0, 0, 0, 0, 0, 0);
        add(OP_CLEAR, MAXC, MINC, MAXC, MINC, MAXC, 1);
        add(OP_POINT, MAXC, MAXC, 0, 0, 0, 0);
        add(OP_CIRCLE, MINC, MINC, 0, 0, MAXC, 0);
        add(OP_CIRCLE, MAXC, MAXC, 0, 0, 0, 0);
        add(OP_FIRST, 300, 300, 0, 0, 0, 1);
        add(OP_FIRST, MINC, 0, 0, 0, 0, 0);
        add(OP_NEXT, MAXC, 0, 0, 0, 0, 0);
        add(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        add(OP_NEXT, MAXC, 0, 0, 0, 0, 0);             // degenerate segment
        add(OP_RECT, -1000, -1000, 1000, 1000, 0, 0);
        add(OP_RECT, MINC, MINC, MAXC, MAXC, 0, 0);
        add(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        add(OP_RECT, 200, -900, 200, 900, 0, 0);       // collapsed onto a line
        add(OP_RECT, 700, 700, 700, 700, 0, 0);        // collapsed onto a point
        add(3'd6, 0, 0, 0, 0, 0, 0);
        add(3'd7, MAXC, MAXC, MAXC, MAXC, MAXC, 1);
        hold_sender = 1'b0;
        drain();

        write_reg(REG_PRECISION, 24'h7FFFFF);
        write_reg(REG_QUERY_X, 24'h800000);
        write_reg(REG_QUERY_Y, 24'h7FFFFF);
        hold_sender = 1'b0;
        add(OP_POINT, MAXC, MINC, 0, 0, 0, 0);
        add(OP_RECT, MINC, MINC, MAXC, MAXC, 0, 0);
        add(OP_FIRST, MAXC, MINC, 0, 0, 0, 0);
        add(OP_NEXT, MINC, MAXC, 0, 0, 0, 0);
        add(OP_CIRCLE, MAXC, MINC, 0, 0, MAXC, 0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 3)
                0: write_reg(REG_PRECISION, 24'($urandom_range(0, 2000)));
                1: write_reg(REG_PRECISION, 24'($urandom));
                default: write_reg(REG_PRECISION, 24'd0);
            endcase
            write_reg(REG_QUERY_X, 24'($urandom));
            write_reg(REG_QUERY_Y, ph == 2 ? 24'h800000 : 24'($urandom));
            for (int k = 0; k < 225; k++) begin
                int pick;
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    // well-formed polyline with a few vertices
                    pending_shapes.push_back(rnd_shape(OP_FIRST));
                    repeat ($urandom_range(1, 4)) pending_shapes.push_back(rnd_shape(OP_NEXT));
                    k += 2;
                end else if (pick == 9) begin
                    pending_shapes.push_back(rnd_shape(3'($urandom_range(0, 7))));
                end else begin
                    pending_shapes.push_back(rnd_shape(3'($urandom_range(0, 5))));
                end
            end
            hold_sender = 1'b0;
            if (ph == 1) begin
                // long receiver stall while items keep coming
                rx_hold = 400;
            end
            if (ph == 4) begin
                // sender pauses until all results have come
                while (pending_shapes.size() > 120) @(posedge i_clk);
                hold_sender = 1'b1;
                while (item_ch.valid || expected_flags.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // end of run
    always @(posedge i_clk) begin
        if (stim_done) begin
            if (mismatches == 0) $display("tb: success");
            else $display("tb: failure");
            $finish;
        end else if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end
endmodule

// File: filelist.f
rtl/core/sphit_pkg.sv
rtl/core/sphit_item_if.sv
rtl/core/sphit_result_if.sv
rtl/core/sphit_dp.sv
rtl/core/sphit_ctrl.sv
rtl/core/shape_proximity_hit_test.sv
tb/sv/tb_top.sv
